FILE: sv/tte_pkg.sv
package tte_pkg;

  // Register port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAP_LIMIT    = 2'd0,
    REG_MIN_INTERVAL = 2'd1
  } reg_index_t;

  // Register widths and reset values
  localparam int GAP_W = 32;
  localparam int MIN_W = 20;
  localparam logic [GAP_W-1:0] GAP_LIMIT_RESET    = 32'd2000000;
  localparam logic [MIN_W-1:0] MIN_INTERVAL_RESET = 20'd100;

  // Result fields
  localparam int CENTI_W = 17;
  localparam int HELD_W  = 4;

  // Tempo scale: 60 s * 1e6 us/s * 100 centi-BPM, and the clamp limits
  localparam int CENTI_NUM_W = 33;
  localparam logic [CENTI_NUM_W-1:0] CENTI_NUM = 33'd6000000000;
  localparam logic [CENTI_W-1:0]     CENTI_MIN = 17'd2000;
  localparam logic [CENTI_W-1:0]     CENTI_MAX = 17'd99900;

endpackage

FILE: sv/tte_ram.sv
module tte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tap_tempo_estimator.sv
// Tap tempo estimator: one result item per accepted tap item.
// Each tap passes gap check, drop, write, span, check, division when there is a tempo, and finish;
// the restoring divider takes one quotient bit per cycle, NUM_W = 33 + clog2(MAX_TAPS).
// A new tap is taken only once the last result is loaded; tap_stall stays high until then.
// rst is synchronous, active high: the window empties and the registers return to defaults.
// The tap window RAM is not cleared; only entries written since the last restart are used.
module tap_tempo_estimator #(
  parameter int MAX_TAPS  = 8,
  parameter int TIME_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration
  input  logic                                  cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0]        cfg_data,
  // Tap channel
  input  logic                                  tap_valid,
  output logic                                  tap_stall,
  input  logic [31:0]                           tap_time_us,
  // Result channel
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic [tte_pkg::CENTI_W-1:0]           bpm_centi,
  output logic                                  tempo_valid,
  output logic [tte_pkg::HELD_W-1:0]            taps_held
);

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int NUM_W  = tte_pkg::CENTI_NUM_W + $clog2(MAX_TAPS);
  localparam int DCNT_W = $clog2(NUM_W + 1);
  localparam int GW     = (TIME_BITS > tte_pkg::GAP_W) ? TIME_BITS : tte_pkg::GAP_W;
  localparam int MP_W   = tte_pkg::MIN_W + CNT_W;
  localparam int CW     = (TIME_BITS > MP_W) ? TIME_BITS : MP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_DROP,
    S_WRITE,
    S_SPAN,
    S_CHECK,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration registers
  logic [tte_pkg::GAP_W-1:0] gap_limit;
  logic [tte_pkg::MIN_W-1:0] min_interval;

  // Window control
  logic [CNT_W-1:0]     count;
  logic [AW-1:0]        head;
  logic [TIME_BITS-1:0] last_time;
  logic [TIME_BITS-1:0] t_reg;

  // Datapath registers
  logic [TIME_BITS-1:0] span;
  logic [MP_W-1:0]      min_prod;
  logic [NUM_W-1:0]     num;
  logic [TIME_BITS-1:0] rem;
  logic [DCNT_W-1:0]    div_cnt;
  logic                 has_tempo;

  // Combinational helpers
  logic [TIME_BITS+31:0] t_ext;
  logic [TIME_BITS-1:0]  t_in;
  logic [TIME_BITS-1:0]  gap;
  logic                  gap_hit;
  logic [SUM_W-1:0]      wr_sum;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         head_next;
  logic [CNT_W-1:0]      n_val;
  logic [TIME_BITS-1:0]  ram_rdata;
  logic                  ram_we;
  logic                  too_short;
  logic [TIME_BITS+1:0]  trial;
  logic                  borrow;
  logic [tte_pkg::CENTI_W-1:0] centi_clamped;
  logic [CNT_W+tte_pkg::HELD_W-1:0] cnt_ext;

  // Tap time taken modulo 2^TIME_BITS.
  assign t_ext = {{TIME_BITS{1'b0}}, tap_time_us};
  assign t_in  = t_ext[TIME_BITS-1:0];

  // Gap since the newest tap, compared at the wider of the two widths.
  assign gap     = t_reg - last_time;
  assign gap_hit = (count != '0) && (GW'(gap) > GW'(gap_limit));

  // Circular window: the newest entry goes at head + count.
  assign wr_sum  = SUM_W'(head) + SUM_W'(count);
  assign wr_addr = (wr_sum >= SUM_W'(MAX_TAPS)) ? AW'(wr_sum - SUM_W'(MAX_TAPS))
                                                : AW'(wr_sum);
  assign head_next = (head == AW'(MAX_TAPS - 1)) ? '0 : head + AW'(1);
  assign ram_we    = (state == S_WRITE);

  assign n_val     = count - CNT_W'(1);
  assign too_short = (count < CNT_W'(2)) || (CW'(span) <= CW'(min_prod));

  // One restoring division step per cycle.
  assign trial  = {1'b0, rem, num[NUM_W-1]} - {2'b00, span};
  assign borrow = trial[TIME_BITS+1];

  // Clamp the quotient into the reported tempo range.
  always_comb begin
    if (num > NUM_W'(tte_pkg::CENTI_MAX)) begin
      centi_clamped = tte_pkg::CENTI_MAX;
    end else if (num < NUM_W'(tte_pkg::CENTI_MIN)) begin
      centi_clamped = tte_pkg::CENTI_MIN;
    end else begin
      centi_clamped = num[tte_pkg::CENTI_W-1:0];
    end
  end

  assign cnt_ext = {{tte_pkg::HELD_W{1'b0}}, count};

  tte_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_TAPS)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (t_reg),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit    <= tte_pkg::GAP_LIMIT_RESET;
      min_interval <= tte_pkg::MIN_INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tte_pkg::REG_GAP_LIMIT:    gap_limit    <= cfg_data[tte_pkg::GAP_W-1:0];
        tte_pkg::REG_MIN_INTERVAL: min_interval <= cfg_data[tte_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, window control and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_stall <= 1'b0;
      res_valid <= 1'b0;
      count     <= '0;
      head      <= '0;
    end else begin
      if (res_valid && !res_stall && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tap_valid) begin
            t_reg     <= t_in;
            tap_stall <= 1'b1;
            state     <= S_GAP;
          end
        end
        // A long gap or a timestamp going backwards restarts the window.
        S_GAP: begin
          if (gap_hit) begin
            count <= '0;
          end
          state <= S_DROP;
        end
        // A full window drops its oldest tap.
        S_DROP: begin
          if (count == CNT_W'(MAX_TAPS)) begin
            head  <= head_next;
            count <= count - CNT_W'(1);
          end
          state <= S_WRITE;
        end
        // Store the tap; the oldest entry is read at head meanwhile.
        S_WRITE: begin
          count     <= count + CNT_W'(1);
          last_time <= t_reg;
          state     <= S_SPAN;
        end
        S_SPAN: begin
          span     <= t_reg - ram_rdata;
          min_prod <= MP_W'(min_interval) * MP_W'(n_val);
          num      <= NUM_W'(tte_pkg::CENTI_NUM) * NUM_W'(n_val);
          state    <= S_CHECK;
        end
        S_CHECK: begin
          rem     <= '0;
          div_cnt <= DCNT_W'(NUM_W);
          if (too_short) begin
            has_tempo <= 1'b0;
            state     <= S_FINISH;
          end else begin
            has_tempo <= 1'b1;
            state     <= S_DIV;
          end
        end
        // The numerator shifts out at the top while quotient bits shift in.
        S_DIV: begin
          if (!borrow) begin
            rem <= trial[TIME_BITS-1:0];
          end else begin
            rem <= {rem[TIME_BITS-2:0], num[NUM_W-1]};
          end
          num     <= {num[NUM_W-2:0], !borrow};
          div_cnt <= div_cnt - DCNT_W'(1);
          if (div_cnt == DCNT_W'(1)) begin
            state <= S_FINISH;
          end
        end
        // Load the result once the result register is free.
        S_FINISH: begin
          if (!res_valid || !res_stall) begin
            res_valid   <= 1'b1;
            bpm_centi   <= has_tempo ? centi_clamped : '0;
            tempo_valid <= has_tempo;
            taps_held   <= cnt_ext[tte_pkg::HELD_W-1:0];
            tap_stall   <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/tte_checker.sv
module tte_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          tap_valid,
  input logic                          tap_stall,
  input logic                          res_valid,
  input logic                          res_stall,
  input logic [tte_pkg::CENTI_W-1:0]   bpm_centi,
  input logic                          tempo_valid,
  input logic [tte_pkg::HELD_W-1:0]    taps_held
);

  // A stalled result item holds its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(bpm_centi) && $stable(tempo_valid)
      && $stable(taps_held))
    else $error("result item changed while stalled");

  // A valid tempo lies within the clamp range.
  a_tempo_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && tempo_valid |->
      bpm_centi >= tte_pkg::CENTI_MIN && bpm_centi <= tte_pkg::CENTI_MAX)
    else $error("tempo outside clamp range");

  // No tempo means a zero value, and fewer than two taps never give a tempo.
  a_no_tempo: assert property (@(posedge clk) disable iff (rst)
    res_valid && (!tempo_valid || taps_held < 4'd2) |-> !tempo_valid && bpm_centi == '0)
    else $error("tempo reported without enough taps or nonzero value");

  // Every result holds at least the tap that caused it.
  a_held_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> taps_held != '0)
    else $error("result with an empty window");

  // An accepted tap keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    tap_valid && !tap_stall |=> tap_stall)
    else $error("block not busy after accepting a tap");

endmodule

bind tap_tempo_estimator tte_checker u_tte_checker (
  .clk         (clk),
  .rst         (rst),
  .tap_valid   (tap_valid),
  .tap_stall   (tap_stall),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .bpm_centi   (bpm_centi),
  .tempo_valid (tempo_valid),
  .taps_held   (taps_held)
);
